@@ design/mpw_pkg.sv @@
// ----------------------------------------------------------------------------
// mpw_pkg: shared types and constants of the page-table walker
// Operation codes, register indexes, the stored entry layout and the
// allocator control group.
// ----------------------------------------------------------------------------
`default_nettype none

package mpw_pkg;

  localparam int IDX_W   = 9;   // index bits per level
  localparam int VPN_W   = 45;
  localparam int PPN_W   = 52;
  localparam int CFG_W   = 7;   // widest register
  localparam int ROOT_W  = 6;
  localparam int LVL_W   = 3;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_MAP   = 2'd1,
    OP_UNMAP = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_ROOT_FRAME = 1'b0,
    CFG_FIRST_FREE = 1'b1
  } cfg_idx_t;

  // Bits 11..1 of an entry are always zero, so only the frame and valid bit
  // are kept.
  typedef struct packed {
    logic [PPN_W-1:0] frame;
    logic             valid;
  } pte_t;

  localparam int ENTRY_W = $bits(pte_t);

  typedef struct packed {
    logic             take;      // hand out the current frame
    logic             load;      // reload from the register write
    logic [CFG_W-1:0] load_val;
  } alloc_ctl_t;

endpackage

`default_nettype wire

@@ design/mpw_ram.sv @@
// ----------------------------------------------------------------------------
// mpw_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
`default_nettype none

module mpw_ram #(
  parameter int WIDTH = 53,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/mpw_alloc.sv @@
// ----------------------------------------------------------------------------
// mpw_alloc: bump allocator for page-table frames
// Holds the next free frame, reloads it on a register write and flags
// exhaustion once it reaches the frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module mpw_alloc
  import mpw_pkg::*;
#(
  parameter int FRAMES = 64,
  parameter int NFW    = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire alloc_ctl_t       ctl,
  output logic      [NFW-1:0]   next_frame,
  output logic                  exhausted
);

  logic [NFW-1:0] next_free_r, next_free_nxt;

  always_comb begin
    next_free_nxt = next_free_r;
    if (ctl.load) begin
      next_free_nxt = NFW'(ctl.load_val);
    end else if (ctl.take) begin
      next_free_nxt = next_free_r + NFW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= NFW'(1);
    end else begin
      next_free_r <= next_free_nxt;
    end
  end

  assign next_frame = next_free_r;
  assign exhausted  = (next_free_r >= NFW'(FRAMES));

endmodule

`default_nettype wire

@@ design/multilevel_page_table_walker_core.sv @@
// Walk: the beat is taken, then each table level is a RAM read followed by an
//   evaluate/update step, then the result posts; a map leaf is written without a
//   read, an unsupported operation skips the walk, and a full output adds stalls.
// Throughput: one request at a time, the next beat taken once the result posts.
// Reset: synchronous, active low; a clearing pass zeroes all FRAMES*512 entries
//   of page memory (32768 by default) before in_ready rises.
// ----------------------------------------------------------------------------
// multilevel_page_table_walker_core: radix page-table walker with own memory
// Walks a LEVELS-deep radix table in a private frame memory, serving query,
// map (with table allocation) and unmap requests.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_page_table_walker_core
  import mpw_pkg::*;
#(
  parameter int FRAMES = 64,
  parameter int LEVELS = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration writes
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_operation,
  input  wire logic [VPN_W-1:0]   in_vpn,
  input  wire logic [PPN_W-1:0]   in_ppn,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_found,
  output logic [PPN_W-1:0]        out_mapped_ppn,
  output logic                    out_status
);

  // Memory geometry: frame number on top, 9-bit table index below.
  localparam int DEPTH = FRAMES * 512;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = AW - IDX_W;
  localparam int VW    = IDX_W * LEVELS;
  // Allocator must count up to FRAMES and hold any 7-bit register value.
  localparam int NFW   = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  op_t              op_r, op_nxt;
  logic [VW-1:0]    vpn_r, vpn_nxt;
  logic [PPN_W-1:0] ppn_r, ppn_nxt;
  logic [PPN_W-1:0] table_r, table_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic             rd_oob_r, rd_oob_nxt;
  logic             res_found_r, res_found_nxt;
  logic [PPN_W-1:0] res_ppn_r, res_ppn_nxt;
  logic             res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [PPN_W-1:0] out_ppn_r, out_ppn_nxt;
  logic             out_status_r, out_status_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  // page memory port signals
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  pte_t               mem_wdata;
  logic               mem_re;
  logic [ENTRY_W-1:0] mem_rdata;

  // allocator
  alloc_ctl_t     alloc_ctl;
  logic [NFW-1:0] next_frame;
  logic           alloc_exhausted;

  // walk datapath
  logic [IDX_W-1:0] idx;
  logic [AW-1:0]    walk_addr;
  logic             tbl_ok;
  logic             last_lvl;
  pte_t             rd_e;

  mpw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_page_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (walk_addr),
    .rdata (mem_rdata)
  );

  mpw_alloc #(
    .FRAMES (FRAMES),
    .NFW    (NFW)
  ) u_alloc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (alloc_ctl),
    .next_frame (next_frame),
    .exhausted  (alloc_exhausted)
  );

  // Current level's index sits in the top 9 bits of the shifted VPN.
  assign idx       = vpn_r[VW-1 -: IDX_W];
  assign walk_addr = {table_r[FW-1:0], idx};
  // A table pointer past the last frame reads as zero and drops writes.
  assign tbl_ok    = (table_r < PPN_W'(FRAMES));
  assign last_lvl  = (lvl_r == LVL_W'(LEVELS));
  assign rd_e      = rd_oob_r ? '0 : pte_t'(mem_rdata);

  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    vpn_nxt        = vpn_r;
    ppn_nxt        = ppn_r;
    table_nxt      = table_r;
    lvl_nxt        = lvl_r;
    rd_oob_nxt     = rd_oob_r;
    res_found_nxt  = res_found_r;
    res_ppn_nxt    = res_ppn_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_ppn_nxt    = out_ppn_r;
    out_status_nxt = out_status_r;
    root_nxt       = root_r;
    mem_we         = 1'b0;
    mem_waddr      = walk_addr;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    alloc_ctl      = '0;

    // Register writes are to come only while idle; the block does not enforce this and takes them in any state.
    if (cfg_we) begin
      if (cfg_idx == CFG_ROOT_FRAME) begin
        root_nxt = cfg_wdata[ROOT_W-1:0];
      end else begin
        alloc_ctl.load     = 1'b1;
        alloc_ctl.load_val = cfg_wdata;
      end
    end

    case (state_r)
      S_CLR: begin
        // Zero one entry per cycle; hold off requests until done.
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = op_t'(in_operation);
          vpn_nxt        = in_vpn[VW-1:0];
          ppn_nxt        = in_ppn;
          table_nxt      = PPN_W'(root_r);
          lvl_nxt        = LVL_W'(1);
          res_found_nxt  = 1'b0;
          res_ppn_nxt    = '0;
          res_status_nxt = 1'b0;
          state_nxt      = (op_t'(in_operation) == OP_NONE) ? S_DONE : S_RD;
        end
      end

      S_RD: begin
        if (op_r == OP_MAP && last_lvl) begin
          // Map leaf: write the translation outright, no read needed.
          mem_we    = tbl_ok;
          mem_wdata = '{frame: ppn_r, valid: 1'b1};
          state_nxt = S_DONE;
        end else begin
          mem_re     = tbl_ok;
          rd_oob_nxt = !tbl_ok;
          state_nxt  = S_EV;
        end
      end

      S_EV: begin
        state_nxt = S_DONE;
        if (op_r == OP_QUERY) begin
          if (rd_e.valid) begin
            if (last_lvl) begin
              res_found_nxt = 1'b1;
              res_ppn_nxt   = rd_e.frame;
            end else begin
              table_nxt = rd_e.frame;
              lvl_nxt   = lvl_r + LVL_W'(1);
              vpn_nxt   = vpn_r << IDX_W;
              state_nxt = S_RD;
            end
          end
        end else if (last_lvl) begin
          // Unmap leaf: clear only the valid bit.
          mem_we    = tbl_ok;
          mem_wdata = '{frame: rd_e.frame, valid: 1'b0};
        end else if (rd_e.valid) begin
          table_nxt = rd_e.frame;
          lvl_nxt   = lvl_r + LVL_W'(1);
          vpn_nxt   = vpn_r << IDX_W;
          state_nxt = S_RD;
        end else if (op_r == OP_MAP) begin
          if (alloc_exhausted) begin
            // Out of frames: stop, tables built so far stay.
            res_status_nxt = 1'b1;
          end else begin
            // Link a fresh table and follow it without re-reading.
            mem_we         = tbl_ok;
            mem_wdata      = '{frame: PPN_W'(next_frame), valid: 1'b1};
            alloc_ctl.take = 1'b1;
            table_nxt      = PPN_W'(next_frame);
            lvl_nxt        = lvl_r + LVL_W'(1);
            vpn_nxt        = vpn_r << IDX_W;
            state_nxt      = S_RD;
          end
        end
        // Unmap with a missing level ends here with status ok.
      end

      S_DONE: begin
        // Post the result once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_ppn_nxt    = res_ppn_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      root_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      root_r      <= root_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    vpn_r        <= vpn_nxt;
    ppn_r        <= ppn_nxt;
    table_r      <= table_nxt;
    lvl_r        <= lvl_nxt;
    rd_oob_r     <= rd_oob_nxt;
    res_found_r  <= res_found_nxt;
    res_ppn_r    <= res_ppn_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_ppn_r    <= out_ppn_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_mapped_ppn = out_ppn_r;
  assign out_status     = out_status_r;

  // A query hit and an allocation failure never share one result beat.
  a_found_xor_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_status))
    else $error("found and status both set");

  // The allocator only moves up unless the register reloads it.
  a_alloc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_we && cfg_idx == CFG_FIRST_FREE) |=> next_frame >= $past(next_frame))
    else $error("allocator moved backward");

  // An accepted beat always starts a walk or posts a result.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == S_RD || state_r == S_DONE))
    else $error("accepted beat left walker idle");

endmodule

`default_nettype wire

@@ sim/multilevel_page_table_walker_core_tb.sv @@
// ----------------------------------------------------------------------------
// multilevel_page_table_walker_core_tb: self-checking bench for the walker
// Feeds query, map, unmap and unused beats via a valid/ready driver. A private
// copy of the frame memory and the allocator predicts every result, and a
// monitor compares each result beat against the oldest prediction. Register
// writes happen only between phases, while the walker is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_page_table_walker_core_tb;
  import mpw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES      = 64;
  localparam int LEVELS      = 5;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASES      = 9;

  typedef struct packed {
    op_t              op;
    logic [VPN_W-1:0] vpn;
    logic [PPN_W-1:0] ppn;
  } walk_req_t;

  typedef struct packed {
    logic             found;
    logic [PPN_W-1:0] mapped_ppn;
    logic             status;
  } walk_result_t;

  // DUT connections; every input starts at a known value
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_idx = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_operation = '0;
  logic [VPN_W-1:0]   in_vpn = '0;
  logic [PPN_W-1:0]   in_ppn = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_found;
  logic [PPN_W-1:0]   out_mapped_ppn;
  logic               out_status;

  // Shadow of the walker: frame memory, registers and bump allocator
  pte_t               page_frames [FRAMES*512];
  int                 root_frame;
  int                 first_free;
  int                 next_free;

  walk_req_t          walk_requests[$];     // beats waiting to be driven
  walk_result_t       predicted_results[$]; // results owed by the walker
  logic [VPN_W-1:0]   mapped_vpns[$];       // recent map targets, reused later
  logic [VPN_W-10:0]  prefix_pool [8];      // shared upper indices

  walk_req_t          cur_req;
  int                 in_gap;
  int                 out_stall;
  int                 calm_left [2];
  int                 fail_count;
  int                 cycle_count;

  multilevel_page_table_walker_core #(
    .FRAMES (FRAMES),
    .LEVELS (LEVELS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_vpn         (in_vpn),
    .in_ppn         (in_ppn),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_mapped_ppn (out_mapped_ppn),
    .out_status     (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow memory access. Frames past the end of memory read as zero and
  // swallow writes.
  // --------------------------------------------------------------------------
  function automatic pte_t read_pte(logic [PPN_W-1:0] frame, logic [IDX_W-1:0] idx);
    pte_t e;
    e = '0;
    if (frame < FRAMES) e = page_frames[{frame[5:0], idx}];
    return e;
  endfunction

  function automatic void write_pte(logic [PPN_W-1:0] frame, logic [IDX_W-1:0] idx,
                                    pte_t e);
    if (frame < FRAMES) page_frames[{frame[5:0], idx}] = e;
  endfunction

  // Level 1 takes the most significant index
  function automatic logic [IDX_W-1:0] level_idx(logic [VPN_W-1:0] vpn, int lvl);
    return vpn[IDX_W*(LEVELS-lvl) +: IDX_W];
  endfunction

  // --------------------------------------------------------------------------
  // Walk the shadow tables for one request and update them as the walker
  // would: allocate missing tables on map, clear only the leaf valid bit on
  // unmap, and stop with status set once the allocator runs dry.
  // --------------------------------------------------------------------------
  function automatic walk_result_t walk_tables(walk_req_t req);
    walk_result_t     res;
    logic [PPN_W-1:0] tbl;
    logic [IDX_W-1:0] idx;
    pte_t             e;
    bit               go;
    int               lvl;
    res = '0;
    tbl = PPN_W'(root_frame);
    go  = 1'b1;
    case (req.op)
      OP_QUERY: begin
        for (lvl = 1; lvl <= LEVELS && go; lvl++) begin
          e = read_pte(tbl, level_idx(req.vpn, lvl));
          if (e.valid) tbl = e.frame;
          else go = 1'b0;
        end
        if (go) begin
          res.found      = 1'b1;
          res.mapped_ppn = tbl;   // leaf frame field is the mapped PPN
        end
      end
      OP_MAP, OP_UNMAP: begin
        for (lvl = 1; lvl < LEVELS && go; lvl++) begin
          idx = level_idx(req.vpn, lvl);
          e   = read_pte(tbl, idx);
          if (e.valid) begin
            tbl = e.frame;
          end else if (req.op == OP_UNMAP) begin
            go = 1'b0;
          end else if (next_free >= FRAMES) begin
            res.status = 1'b1;
            go = 1'b0;
          end else begin
            // Link the fresh table and follow it without re-reading
            e.frame = PPN_W'(next_free);
            e.valid = 1'b1;
            write_pte(tbl, idx, e);
            tbl = PPN_W'(next_free);
            next_free++;
          end
        end
        if (go) begin
          idx = level_idx(req.vpn, LEVELS);
          if (req.op == OP_UNMAP) begin
            e = read_pte(tbl, idx);
            e.valid = 1'b0;
          end else begin
            e.frame = req.ppn;
            e.valid = 1'b1;
          end
          write_pte(tbl, idx, e);
        end
      end
      default: ;  // unused operation: no change, all-zero result
    endcase
    return res;
  endfunction

  // Idle length for one beat; side 0 is the request driver, side 1 the
  // result sink. Now and then a calm stretch with no idling at all.
  function automatic int draw_gap(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic void queue_req(op_t op, logic [VPN_W-1:0] vpn,
                                    logic [PPN_W-1:0] ppn);
    walk_req_t r;
    r.op  = op;
    r.vpn = vpn;
    r.ppn = ppn;
    walk_requests.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Hold valid and payload until the beat is taken; predict
  // on acceptance so the shadow state moves in beat order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(walk_tables(cur_req));
        in_gap = draw_gap(0);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (walk_requests.size() > 0) begin
          cur_req = walk_requests.pop_front();
          in_operation <= cur_req.op;
          in_vpn       <= cur_req.vpn;
          in_ppn       <= cur_req.ppn;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Check every taken beat against the oldest prediction,
  // then drop ready for a random stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    walk_result_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat with none expected: found %0b ppn %h status %0b",
                   $time, out_found, out_mapped_ppn, out_status);
          fail_count++;
        end else begin
          exp_res = predicted_results.pop_front();
          if (out_found !== exp_res.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, exp_res.found, out_found);
            fail_count++;
          end
          if (out_mapped_ppn !== exp_res.mapped_ppn) begin
            $display("%0t: mapped_ppn mismatch: expected %h, actual %h",
                     $time, exp_res.mapped_ppn, out_mapped_ppn);
            fail_count++;
          end
          if (out_status !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0b, actual %0b",
                     $time, exp_res.status, out_status);
            fail_count++;
          end
        end
        out_stall = draw_gap(1);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Block until every queued beat is taken and every result has come back
  task automatic drain();
    @(posedge clk);
    while (walk_requests.size() > 0 || in_valid || predicted_results.size() > 0)
      @(posedge clk);
  endtask

  // Register write; the shadow copy follows at the write edge
  task automatic write_reg(cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_ROOT_FRAME) begin
      root_frame = val & 63;
    end else begin
      first_free = val & 127;
      next_free  = first_free;
    end
  endtask

  task automatic set_phase(int root, int free_frame);
    drain();
    write_reg(CFG_ROOT_FRAME, root);
    write_reg(CFG_FIRST_FREE, free_frame);
  endtask

  // Mostly walks that share upper tables, so maps land where queries and
  // unmaps will look; the rest are recent map targets and fully random VPNs.
  task automatic queue_random_items(int count);
    logic [VPN_W-1:0] vpn;
    op_t              op;
    int               r;
    for (int i = 0; i < count; i++) begin
      r  = $urandom_range(0, 99);
      op = (r < 40) ? OP_QUERY : (r < 75) ? OP_MAP : (r < 93) ? OP_UNMAP : OP_NONE;
      r  = $urandom_range(0, 99);
      if (r < 55)
        vpn = {prefix_pool[$urandom_range(0, 7)], IDX_W'($urandom_range(0, 15))};
      else if (r < 85 && mapped_vpns.size() > 0)
        vpn = mapped_vpns[$urandom_range(0, mapped_vpns.size() - 1)];
      else
        vpn = VPN_W'({$urandom, $urandom});
      if (op == OP_MAP) begin
        mapped_vpns.push_back(vpn);
        if (mapped_vpns.size() > 48) void'(mapped_vpns.pop_front());
      end
      queue_req(op, vpn, PPN_W'({$urandom, $urandom}));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int root;
    int free_frame;
    foreach (page_frames[i]) page_frames[i] = '0;
    root_frame = 0;
    first_free = 1;
    next_free  = 1;
    fail_count = 0;
    foreach (calm_left[i]) calm_left[i] = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: root frame 0, allocator from frame 1.
    // Empty tables, then a path built at frames 1..4 for VPN 0.
    queue_req(OP_QUERY, '0, '0);
    queue_req(OP_MAP,   '0, '0);
    queue_req(OP_QUERY, '0, '1);
    // All-ones VPN and PPN on a second path
    queue_req(OP_MAP,   '1, '1);
    queue_req(OP_QUERY, '1, '0);
    // Neighbor leaf on the VPN 0 path: no allocation needed
    queue_req(OP_MAP,   45'd1, 52'h5_A5A5_A5A5_A5A5);
    queue_req(OP_QUERY, 45'd1, '0);
    // Unmap clears only the leaf; an absent upper level stops the unmap early
    queue_req(OP_UNMAP, '0, '0);
    queue_req(OP_QUERY, '0, '0);
    queue_req(OP_UNMAP, {9'h100, 36'd0}, '0);
    queue_req(OP_QUERY, 45'd1, '0);
    // Unused operation with every payload bit set
    queue_req(OP_NONE,  '1, '1);
    queue_req(OP_MAP,   '0, 52'hA_AAAA_AAAA_AAAA);
    queue_req(OP_QUERY, '0, '0);

    // Two frames left: the walk allocates them and then runs dry
    set_phase(0, 62);
    queue_req(OP_MAP,   {9'h0AB, 36'd0}, 52'h1234);
    queue_req(OP_QUERY, {9'h0AB, 36'd0}, '0);
    queue_req(OP_MAP,   45'd2, 52'h77);

    // Root on a leaf table: its entries point past the end of memory
    set_phase(4, 64);
    queue_req(OP_QUERY, {9'd1, 36'd0}, '0);
    queue_req(OP_MAP,   {9'd1, 36'd0}, 52'h99);

    // Same, with frames to hand out: links into the missing frame are lost
    set_phase(4, 9);
    queue_req(OP_MAP,   {9'd1, 36'd0}, 52'h99);
    queue_req(OP_QUERY, {9'd1, 36'd0}, '0);

    // Highest root, allocator starting at frame 0 on top of live tables
    set_phase(63, 0);
    queue_req(OP_MAP,   {9'h055, 9'h0AA, 9'h1C3, 9'h03C, 9'h1FF}, 52'hF_0F0F_0F0F_0F0F);
    queue_req(OP_QUERY, {9'h055, 9'h0AA, 9'h1C3, 9'h03C, 9'h1FF}, '0);

    // Random phases over a spread of register settings, extremes included
    foreach (prefix_pool[i])
      prefix_pool[i] = {(i % 2 == 0) ? 9'd0 : 9'h1FF, 9'($urandom_range(0, 3)),
                        18'($urandom)};
    for (int p = 0; p < PHASES; p++) begin
      root       = (p % 3 == 0) ? 0 : (p == 1) ? 63 : $urandom_range(0, 63);
      free_frame = (p == 1) ? 64 : (p == 2) ? 0 : (p == 3) ? 1 : $urandom_range(0, 40);
      set_phase(root, free_frame);
      queue_random_items(PHASE_ITEMS);
    end

    drain();
    repeat (2 * LEVELS + 4) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/mpw_pkg.sv
design/mpw_ram.sv
design/mpw_alloc.sv
design/multilevel_page_table_walker_core.sv
sim/multilevel_page_table_walker_core_tb.sv
